### rtl/core/midi_track_event_parser_assert.svh
// ----------------------------------------------------------------------------
// midi_track_event_parser_assert.svh
// assertion macros used by the checker file of the track parser
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH

// property checked at every clock edge outside reset
`define MTEP_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define MTEP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	`MTEP_ASSERT_ALWAYS(lbl, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define MTEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	`MTEP_ASSERT_ALWAYS(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

### rtl/core/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// types and constants of the midi track event parser
// ----------------------------------------------------------------------------
package mtep_pkg;

	localparam int unsigned EVENT_CAPACITY_DEF = 2048;
	localparam int unsigned COUNT_W            = 12;

	// status bytes and status high nibbles
	localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
	localparam logic [7:0] ST_NOTE_ON    = 8'h90;
	localparam logic [7:0] ST_POLY_AT    = 8'ha0;
	localparam logic [7:0] ST_CTRL       = 8'hb0;
	localparam logic [7:0] ST_PROG       = 8'hc0;
	localparam logic [7:0] ST_CHAN_AT    = 8'hd0;
	localparam logic [7:0] ST_PITCH      = 8'he0;
	localparam logic [7:0] ST_SYSTEM     = 8'hf0;
	localparam logic [7:0] ST_SYSEX      = 8'hf0;
	localparam logic [7:0] ST_SYSEX_ESC  = 8'hf7;
	localparam logic [7:0] ST_META       = 8'hff;
	localparam logic [7:0] HI_MASK       = 8'hf0;

	localparam logic [7:0] META_END_TRACK = 8'h2f;
	localparam logic [7:0] META_TEMPO     = 8'h51;

	typedef enum logic [3:0] {
		PH_DELTA     = 4'd0,
		PH_CMD       = 4'd1,
		PH_NOTE_KEY  = 4'd2,
		PH_NOTE_VEL  = 4'd3,
		PH_RUN_VEL   = 4'd4,
		PH_SKIP      = 4'd5,
		PH_SYSEX_LEN = 4'd6,
		PH_META_TYPE = 4'd7,
		PH_META_LEN  = 4'd8,
		PH_TEMPO     = 4'd9,
		PH_DONE      = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NOTE  = 2'd0,
		KIND_TEMPO = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       track_start;
	} byte_item_t;

	typedef struct packed {
		kind_t       kind;
		logic        note_on;
		logic [3:0]  channel;
		logic [7:0]  note_number;
		logic [7:0]  velocity;
		logic [31:0] delta_ticks;
		logic [31:0] tempo_value;
		logic        store_full;
	} event_item_t;

	typedef struct packed {
		logic        valid;
		event_item_t item;
	} step_out_t;

	typedef struct packed {
		phase_t             phase;
		logic [31:0]        delta_sum;
		logic [31:0]        varlen_value;
		logic               last_is_note_on;
		logic [3:0]         last_channel;
		logic [7:0]         pending_status;
		logic [7:0]         pending_note;
		logic [31:0]        bytes_to_skip;
		logic [7:0]         meta_kind;
		logic [31:0]        tempo_sum;
		logic [COUNT_W-1:0] event_count;
		logic               halted;
	} parse_state_t;

endpackage

### rtl/core/mtep_stream_if.sv
// ----------------------------------------------------------------------------
// mtep_stream_if
// valid/ready channel with a typed payload
// ----------------------------------------------------------------------------
interface mtep_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/mtep_parser.sv
// ----------------------------------------------------------------------------
// mtep_parser
// parse state registers and the one-byte step of the track parser
// ----------------------------------------------------------------------------
module mtep_parser #(
	parameter int unsigned EVENT_CAPACITY = mtep_pkg::EVENT_CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  mtep_pkg::byte_item_t item,
	output mtep_pkg::step_out_t  res
);
	import mtep_pkg::*;

	parse_state_t       state_q;
	parse_state_t       cur;
	parse_state_t       nx;
	logic [7:0]         b;
	logic [7:0]         hi;
	logic [31:0]        vl_next;
	logic               vl_done;
	logic [31:0]        skip_dec;
	logic [31:0]        tempo_next;
	logic [COUNT_W-1:0] cnt_next;
	logic               emit_go;
	logic               emit_on;
	logic [3:0]         emit_ch;

	assign b          = item.data_byte;
	assign hi         = b & HI_MASK;
	assign vl_next    = {cur.varlen_value[24:0], 7'b0} + {25'b0, b[6:0]};
	assign vl_done    = !b[7];
	assign skip_dec   = cur.bytes_to_skip - 32'd1;
	assign tempo_next = {cur.tempo_sum[23:0], b};
	assign cnt_next   = cur.event_count + COUNT_W'(1);

	// track start clears the delta and end state before the byte is read
	always_comb begin
		cur = state_q;
		if (item.track_start) begin
			cur.delta_sum     = '0;
			cur.varlen_value  = '0;
			cur.bytes_to_skip = '0;
			cur.phase         = PH_DELTA;
		end
	end

	always_comb begin
		nx      = cur;
		res     = '0;
		emit_go = 1'b0;
		emit_on = 1'b0;
		emit_ch = '0;
		unique case (cur.phase)
			PH_CMD: begin
				if (hi == ST_NOTE_OFF || hi == ST_NOTE_ON) begin
					nx.pending_status = b;
					nx.phase          = PH_NOTE_KEY;
				end else if (!b[7]) begin
					// running status
					nx.pending_note = b;
					nx.phase        = PH_RUN_VEL;
				end else if (hi == ST_POLY_AT || hi == ST_CTRL || hi == ST_PITCH) begin
					nx.bytes_to_skip = 32'd2;
					nx.phase         = PH_SKIP;
				end else if (hi == ST_PROG || hi == ST_CHAN_AT) begin
					nx.bytes_to_skip = 32'd1;
					nx.phase         = PH_SKIP;
				end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
					nx.varlen_value = '0;
					nx.phase        = PH_SYSEX_LEN;
				end else if (b == ST_META) begin
					nx.phase = PH_META_TYPE;
				end else begin
					nx.phase = PH_DELTA;
				end
			end
			PH_NOTE_KEY: begin
				nx.pending_note = b;
				nx.phase        = PH_NOTE_VEL;
			end
			PH_NOTE_VEL: begin
				emit_go = 1'b1;
				emit_on = (cur.pending_status & HI_MASK) == ST_NOTE_ON;
				emit_ch = cur.pending_status[3:0];
			end
			PH_RUN_VEL: begin
				emit_go = 1'b1;
				emit_on = cur.last_is_note_on;
				emit_ch = cur.last_channel;
			end
			PH_SKIP: begin
				nx.bytes_to_skip = skip_dec;
				if (skip_dec == '0) begin
					nx.phase = PH_DELTA;
				end
			end
			PH_SYSEX_LEN: begin
				if (vl_done) begin
					nx.varlen_value  = '0;
					nx.bytes_to_skip = vl_next;
					nx.phase         = (vl_next != '0) ? PH_SKIP : PH_DELTA;
				end else begin
					nx.varlen_value = vl_next;
				end
			end
			PH_META_TYPE: begin
				nx.meta_kind    = b;
				nx.varlen_value = '0;
				nx.phase        = PH_META_LEN;
			end
			PH_META_LEN: begin
				if (!vl_done) begin
					nx.varlen_value = vl_next;
				end else begin
					nx.varlen_value = '0;
					if (cur.meta_kind == META_END_TRACK) begin
						nx.phase       = PH_DONE;
						res.valid      = 1'b1;
						res.item.kind  = KIND_END;
					end else if (cur.meta_kind == META_TEMPO) begin
						nx.tempo_sum = '0;
						if (vl_next == '0) begin
							nx.phase      = PH_DELTA;
							res.valid     = 1'b1;
							res.item.kind = KIND_TEMPO;
						end else begin
							nx.bytes_to_skip = vl_next;
							nx.phase         = PH_TEMPO;
						end
					end else begin
						nx.bytes_to_skip = vl_next;
						nx.phase         = (vl_next != '0) ? PH_SKIP : PH_DELTA;
					end
				end
			end
			PH_TEMPO: begin
				nx.tempo_sum     = tempo_next;
				nx.bytes_to_skip = skip_dec;
				if (skip_dec == '0) begin
					nx.phase             = PH_DELTA;
					res.valid            = 1'b1;
					res.item.kind        = KIND_TEMPO;
					res.item.tempo_value = tempo_next;
				end
			end
			PH_DONE: begin
				nx = cur;
			end
			default: begin
				// delta bytes, also any unused phase code
				if (vl_done) begin
					nx.delta_sum    = cur.delta_sum + vl_next;
					nx.varlen_value = '0;
					nx.phase        = PH_CMD;
				end else begin
					nx.varlen_value = vl_next;
					nx.phase        = PH_DELTA;
				end
			end
		endcase

		if (emit_go) begin
			res.valid              = 1'b1;
			res.item.kind          = KIND_NOTE;
			res.item.note_on       = emit_on;
			res.item.channel       = emit_ch;
			res.item.note_number   = cur.pending_note;
			res.item.velocity      = b;
			res.item.delta_ticks   = cur.delta_sum;
			nx.last_is_note_on     = emit_on;
			nx.last_channel        = emit_ch;
			nx.delta_sum           = '0;
			nx.event_count         = cnt_next;
			nx.phase               = PH_DELTA;
			if (cnt_next >= COUNT_W'(EVENT_CAPACITY)) begin
				nx.halted           = 1'b1;
				res.item.store_full = 1'b1;
			end
		end

		// halted parser ignores every byte until reset
		if (state_q.halted) begin
			nx  = state_q;
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_DELTA, last_is_note_on: 1'b1, default: '0};
		end else if (step_en) begin
			state_q <= nx;
		end
	end
endmodule

### rtl/core/mtep_out_stage.sv
// ----------------------------------------------------------------------------
// mtep_out_stage
// result register in front of the event channel
// ----------------------------------------------------------------------------
module mtep_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  mtep_pkg::step_out_t res,
	output logic                free,
	mtep_stream_if.source       event_ch
);
	import mtep_pkg::*;

	logic        valid_q;
	event_item_t item_q;
	logic        load;

	assign free             = !valid_q || event_ch.ready;
	assign load             = step_en && res.valid;
	assign event_ch.valid   = valid_q;
	assign event_ch.payload = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (event_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= res.item;
		end
	end
endmodule

### rtl/core/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser
// byte-serial midi track body parser: note, tempo and end of track events
//
//   channel    dir   payload                       handshake
//   byte_ch    in    data_byte, track_start        valid/ready
//   event_ch   out   kind, note fields, tempo      valid/ready
//
// one byte per cycle sustained while event_ch does not stall; a byte goes
// input register -> parse step -> result register, which drives event_ch.
// parse state updates as each byte steps, so every byte can follow the last.
// reset clears the parse state; there is no clearing pass.
// a stall on event_ch holds the result register and backs up byte_ch.
// ----------------------------------------------------------------------------
module midi_track_event_parser #(
	parameter int unsigned EVENT_CAPACITY = mtep_pkg::EVENT_CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mtep_stream_if.sink   byte_ch,
	mtep_stream_if.source event_ch
);
	import mtep_pkg::*;

	logic       valid_s1;
	byte_item_t item_s1;
	logic       free;
	logic       step_en;
	logic       accept;
	step_out_t  res;

	assign step_en       = valid_s1 && free;
	assign byte_ch.ready = !valid_s1 || free;
	assign accept        = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_ch.payload;
		end
	end

	mtep_parser #(
		.EVENT_CAPACITY(EVENT_CAPACITY)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(step_en),
		.item   (item_s1),
		.res    (res)
	);

	mtep_out_stage u_out_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.res     (res),
		.free    (free),
		.event_ch(event_ch)
	);
endmodule

### rtl/core/mtep_checker.sv
// ----------------------------------------------------------------------------
// mtep_checker
// port-level checks of the midi track event parser, bound to the top level
// ----------------------------------------------------------------------------
`include "midi_track_event_parser_assert.svh"

module mtep_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input mtep_pkg::event_item_t out_item
);
	import mtep_pkg::*;

	`MTEP_ASSERT_IMPLIES(a_note_no_tempo, clk, arst_n, out_valid && out_item.kind == KIND_NOTE, out_item.tempo_value == '0, "note event carries a tempo value")
	`MTEP_ASSERT_IMPLIES(a_meta_no_note, clk, arst_n, out_valid && out_item.kind != KIND_NOTE, !out_item.note_on && out_item.channel == '0 && out_item.note_number == '0 && out_item.velocity == '0 && out_item.delta_ticks == '0 && !out_item.store_full, "tempo or end result carries note fields")
	`MTEP_ASSERT_IMPLIES(a_end_no_tempo, clk, arst_n, out_valid && out_item.kind == KIND_END, out_item.tempo_value == '0, "end of track carries a tempo value")
	`MTEP_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed or dropped")
	`MTEP_ASSERT_NEXT(a_halt_silent, clk, arst_n, out_valid && out_ready && out_item.store_full, !out_valid, "result after the store filled")
endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(event_ch.valid),
	.out_ready(event_ch.ready),
	.out_item (event_ch.payload)
);

### verif/midi_track_event_parser_tb.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser_tb
// self-checking bench for the byte-serial midi track body parser
//
// a short table of hand-written bytes comes first: running status straight
// after reset, channel and field extremes, the largest four-byte delta, a
// zero-length tempo and end of track. then come random track bodies built
// from note, running status, channel, sysex, meta, tempo and end messages,
// with some broken messages and noise bytes. every accepted byte goes
// through a local parser model; results are checked against it or a typed row.
// ----------------------------------------------------------------------------
module midi_track_event_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtep_pkg::*;

	localparam int unsigned CAPACITY     = EVENT_CAPACITY_DEF;
	localparam int unsigned RANDOM_BYTES = 1750;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct {
		logic [7:0]  data_byte;
		logic        track_start;
		bit          typed;
		event_item_t ev;
	} stim_row_t;

	logic clk;
	logic arst_n;

	mtep_stream_if #(.payload_t(byte_item_t))  byte_if ();
	mtep_stream_if #(.payload_t(event_item_t)) event_if ();

	midi_track_event_parser #(
		.EVENT_CAPACITY(CAPACITY)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_if),
		.event_ch (event_if)
	);

	// parser model state
	phase_t             p_phase    = PH_DELTA;
	logic [31:0]        p_delta    = '0;
	logic [31:0]        p_varlen   = '0;
	logic               p_last_on  = 1'b1;
	logic [3:0]         p_last_ch  = '0;
	logic [7:0]         p_status   = '0;
	logic [7:0]         p_key      = '0;
	logic [31:0]        p_skip     = '0;
	logic [7:0]         p_meta     = '0;
	logic [31:0]        p_tempo    = '0;
	logic [COUNT_W-1:0] p_count    = '0;
	logic               p_halted   = 1'b0;

	event_item_t expected_events[$];

	// hand-typed expectation of the byte on the channel
	bit          next_typed;
	event_item_t next_event;
	bit          row_typed;
	event_item_t row_event;

	bit steady;
	bit hold_req;
	bit hold_done;

	int unsigned bytes_sent;
	int unsigned bytes_ignored;
	int unsigned fails;
	int unsigned n_notes;
	int unsigned n_tempos;
	int unsigned n_ends;
	int unsigned n_full;

	// ------------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------------
	function automatic bit feed_varlen(input logic [7:0] b);
		p_varlen = (p_varlen << 7) + {25'd0, b[6:0]};
		return !b[7];
	endfunction

	function automatic void start_skip(input logic [31:0] len);
		p_skip  = len;
		p_phase = (len != 0) ? PH_SKIP : PH_DELTA;
	endfunction

	function automatic event_item_t make_note(input logic on, input logic [3:0] ch,
			input logic [7:0] vel);
		event_item_t ev;
		ev             = '0;
		ev.kind        = KIND_NOTE;
		ev.note_on     = on;
		ev.channel     = ch;
		ev.note_number = p_key;
		ev.velocity    = vel;
		ev.delta_ticks = p_delta;
		p_last_on = on;
		p_last_ch = ch;
		p_delta   = '0;
		p_count   = p_count + 1'b1;
		if (p_count >= CAPACITY) begin
			p_halted      = 1'b1;
			ev.store_full = 1'b1;
		end
		p_phase = PH_DELTA;
		return ev;
	endfunction

	function automatic bit parse_step(input logic [7:0] b, input logic ts,
			output event_item_t ev);
		logic [7:0]  hi;
		logic [31:0] len;
		ev = '0;
		if (p_halted)
			return 1'b0;
		if (ts) begin
			p_delta  = '0;
			p_varlen = '0;
			p_skip   = '0;
			p_phase  = PH_DELTA;
		end
		hi = b & HI_MASK;
		case (p_phase)
			PH_CMD: begin
				if (hi == ST_NOTE_OFF || hi == ST_NOTE_ON) begin
					p_status = b;
					p_phase  = PH_NOTE_KEY;
				end else if (!b[7]) begin
					// running status: data byte in command position
					p_key   = b;
					p_phase = PH_RUN_VEL;
				end else if (hi == ST_POLY_AT || hi == ST_CTRL || hi == ST_PITCH) begin
					start_skip(2);
				end else if (hi == ST_PROG || hi == ST_CHAN_AT) begin
					start_skip(1);
				end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
					p_varlen = '0;
					p_phase  = PH_SYSEX_LEN;
				end else if (b == ST_META) begin
					p_phase = PH_META_TYPE;
				end else begin
					p_phase = PH_DELTA;
				end
				return 1'b0;
			end
			PH_NOTE_KEY: begin
				p_key   = b;
				p_phase = PH_NOTE_VEL;
				return 1'b0;
			end
			PH_NOTE_VEL: begin
				ev = make_note((p_status & HI_MASK) == ST_NOTE_ON, p_status[3:0], b);
				return 1'b1;
			end
			PH_RUN_VEL: begin
				ev = make_note(p_last_on, p_last_ch, b);
				return 1'b1;
			end
			PH_SKIP: begin
				p_skip = p_skip - 1;
				if (p_skip == 0)
					p_phase = PH_DELTA;
				return 1'b0;
			end
			PH_SYSEX_LEN: begin
				if (feed_varlen(b)) begin
					len      = p_varlen;
					p_varlen = '0;
					start_skip(len);
				end
				return 1'b0;
			end
			PH_META_TYPE: begin
				p_meta   = b;
				p_varlen = '0;
				p_phase  = PH_META_LEN;
				return 1'b0;
			end
			PH_META_LEN: begin
				if (!feed_varlen(b))
					return 1'b0;
				len      = p_varlen;
				p_varlen = '0;
				if (p_meta == META_END_TRACK) begin
					p_phase = PH_DONE;
					ev.kind = KIND_END;
					return 1'b1;
				end
				if (p_meta == META_TEMPO) begin
					p_tempo = '0;
					if (len == 0) begin
						p_phase = PH_DELTA;
						ev.kind = KIND_TEMPO;
						return 1'b1;
					end
					p_skip  = len;
					p_phase = PH_TEMPO;
					return 1'b0;
				end
				start_skip(len);
				return 1'b0;
			end
			PH_TEMPO: begin
				p_tempo = (p_tempo << 8) | {24'd0, b};
				p_skip  = p_skip - 1;
				if (p_skip != 0)
					return 1'b0;
				p_phase        = PH_DELTA;
				ev.kind        = KIND_TEMPO;
				ev.tempo_value = p_tempo;
				return 1'b1;
			end
			PH_DONE: begin
				return 1'b0;
			end
			default: begin
				// delta bytes, and any phase code the parser does not know
				if (feed_varlen(b)) begin
					p_delta  = p_delta + p_varlen;
					p_varlen = '0;
					p_phase  = PH_CMD;
				end else begin
					p_phase = PH_DELTA;
				end
				return 1'b0;
			end
		endcase
	endfunction

	function automatic event_item_t note_event(input logic on, input logic [3:0] ch,
			input logic [7:0] key, input logic [7:0] vel, input logic [31:0] delta);
		event_item_t ev;
		ev             = '0;
		ev.kind        = KIND_NOTE;
		ev.note_on     = on;
		ev.channel     = ch;
		ev.note_number = key;
		ev.velocity    = vel;
		ev.delta_ticks = delta;
		return ev;
	endfunction

	function automatic event_item_t plain_event(input kind_t k);
		event_item_t ev;
		ev      = '0;
		ev.kind = k;
		return ev;
	endfunction

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------
	task automatic check_event(input event_item_t want, input event_item_t got);
		if (got.kind !== want.kind) begin
			$error("kind: expected %0d, got %0d", want.kind, got.kind);
			fails++;
		end
		if (got.note_on !== want.note_on) begin
			$error("note_on: expected %0h, got %0h", want.note_on, got.note_on);
			fails++;
		end
		if (got.channel !== want.channel) begin
			$error("channel: expected %0h, got %0h", want.channel, got.channel);
			fails++;
		end
		if (got.note_number !== want.note_number) begin
			$error("note_number: expected %0h, got %0h", want.note_number, got.note_number);
			fails++;
		end
		if (got.velocity !== want.velocity) begin
			$error("velocity: expected %0h, got %0h", want.velocity, got.velocity);
			fails++;
		end
		if (got.delta_ticks !== want.delta_ticks) begin
			$error("delta_ticks: expected %0h, got %0h", want.delta_ticks, got.delta_ticks);
			fails++;
		end
		if (got.tempo_value !== want.tempo_value) begin
			$error("tempo_value: expected %0h, got %0h", want.tempo_value, got.tempo_value);
			fails++;
		end
		if (got.store_full !== want.store_full) begin
			$error("store_full: expected %0h, got %0h", want.store_full, got.store_full);
			fails++;
		end
	endtask

	always @(posedge clk) begin : monitor
		event_item_t pred;
		event_item_t want;
		bit          hit;
		if (arst_n) begin
			if (byte_if.valid && byte_if.ready) begin
				hit = parse_step(byte_if.payload.data_byte, byte_if.payload.track_start, pred);
				if (row_typed)
					expected_events.push_back(row_event);
				else if (hit)
					expected_events.push_back(pred);
			end
			if (event_if.valid && event_if.ready) begin
				if (expected_events.size() == 0) begin
					$error("result with nothing expected: kind %0d delta %0h",
						event_if.payload.kind, event_if.payload.delta_ticks);
					fails++;
				end else begin
					want = expected_events.pop_front();
					check_event(want, event_if.payload);
				end
				case (event_if.payload.kind)
					KIND_NOTE:  n_notes++;
					KIND_TEMPO: n_tempos++;
					default:    n_ends++;
				endcase
				if (event_if.payload.store_full)
					n_full++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// clock, timeout, result side
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", expected_events.size());
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	initial begin : sink_side
		int unsigned gap;
		event_if.ready = 1'b0;
		forever begin
			if (hold_req) begin
				// long hold-off so the parser backs up into the byte channel
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					event_if.ready <= 1'b0;
				end
				hold_req  = 1'b0;
				hold_done = 1'b1;
			end else begin
				gap = pick_gap();
				repeat (gap) begin
					@(negedge clk);
					event_if.ready <= 1'b0;
				end
				@(negedge clk);
				event_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// byte side
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic ts);
		int unsigned gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			byte_if.valid <= 1'b0;
		end
		@(negedge clk);
		row_typed = next_typed;
		row_event = next_event;
		byte_if.valid   <= 1'b1;
		byte_if.payload <= '{data_byte: b, track_start: ts};
		@(posedge clk);
		while (!byte_if.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_payload(input int unsigned n);
		repeat (n)
			send_byte(8'($urandom), 1'b0);
	endtask

	task automatic send_varlen(input logic [31:0] value, input logic ts);
		int         n;
		logic [7:0] b;
		n = 1;
		while (n < 4 && (value >> (7 * n)) != 0)
			n++;
		for (int i = n - 1; i >= 0; i--) begin
			b = {(i != 0), value[7 * i +: 7]};
			send_byte(b, (i == n - 1) ? ts : 1'b0);
		end
	endtask

	task automatic send_delta(input logic ts);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			send_varlen(32'd0, ts);
		end else if (r < 70) begin
			send_varlen($urandom_range(1, 127), ts);
		end else if (r < 88) begin
			send_varlen($urandom_range(128, 16383), ts);
		end else if (r < 96) begin
			send_varlen($urandom & 32'h0fff_ffff, ts);
		end else begin
			// five groups: the sum wraps past 32 bits
			for (int i = 0; i < 4; i++)
				send_byte({1'b1, 7'($urandom)}, (i == 0) ? ts : 1'b0);
			send_byte({1'b0, 7'($urandom)}, 1'b0);
		end
	endtask

	function automatic int unsigned pick_len();
		int unsigned k;
		k = $urandom_range(0, 19);
		if (k < 4)
			return 0;
		if (k < 18)
			return $urandom_range(1, 10);
		return $urandom_range(128, 140);
	endfunction

	initial begin : stimulus
		stim_row_t   dir_rows[$];
		int unsigned r;
		int unsigned k;
		int unsigned len;
		logic [7:0]  t;
		logic [3:0]  ch;
		bit          new_track;
		bit          hold_started;

		arst_n          = 1'b0;
		byte_if.valid   = 1'b0;
		byte_if.payload = '0;
		steady          = 1'b0;
		hold_req        = 1'b0;
		hold_done       = 1'b0;
		next_typed      = 1'b0;
		next_event      = '0;
		row_typed       = 1'b0;
		row_event       = '0;
		hold_started    = 1'b0;

		// running status before any event, then extremes of channel and fields
		dir_rows.push_back('{8'h00, 1'b1, 1'b0, '0});
		dir_rows.push_back('{8'h3c, 1'b0, 1'b0, '0});
		dir_rows.push_back('{8'h7f, 1'b0, 1'b1, note_event(1'b1, 4'h0, 8'h3c, 8'h7f, 32'd0)});
		dir_rows.push_back('{8'h81, 1'b0, 1'b0, '0});
		dir_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
		dir_rows.push_back('{ST_NOTE_OFF | 8'h0f, 1'b0, 1'b0, '0});
		dir_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
		dir_rows.push_back('{8'h00, 1'b0, 1'b1, note_event(1'b0, 4'hf, 8'h00, 8'h00, 32'd128)});
		dir_rows.push_back('{8'hff, 1'b0, 1'b0, '0});
		dir_rows.push_back('{8'hff, 1'b0, 1'b0, '0});
		dir_rows.push_back('{8'hff, 1'b0, 1'b0, '0});
		dir_rows.push_back('{8'h7f, 1'b0, 1'b0, '0});
		dir_rows.push_back('{ST_NOTE_ON | 8'h0f, 1'b0, 1'b0, '0});
		dir_rows.push_back('{8'hff, 1'b0, 1'b0, '0});
		dir_rows.push_back('{8'hff, 1'b0, 1'b1,
			note_event(1'b1, 4'hf, 8'hff, 8'hff, 32'h0fff_ffff)});
		// zero-length tempo
		dir_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
		dir_rows.push_back('{ST_META, 1'b0, 1'b0, '0});
		dir_rows.push_back('{META_TEMPO, 1'b0, 1'b0, '0});
		dir_rows.push_back('{8'h00, 1'b0, 1'b1, plain_event(KIND_TEMPO)});
		// end of track, then a byte that is ignored
		dir_rows.push_back('{8'h00, 1'b0, 1'b0, '0});
		dir_rows.push_back('{ST_META, 1'b0, 1'b0, '0});
		dir_rows.push_back('{META_END_TRACK, 1'b0, 1'b0, '0});
		dir_rows.push_back('{8'h00, 1'b0, 1'b1, plain_event(KIND_END)});
		dir_rows.push_back('{ST_NOTE_ON, 1'b0, 1'b0, '0});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			next_typed = dir_rows[i].typed;
			next_event = dir_rows[i].ev;
			send_byte(dir_rows[i].data_byte, dir_rows[i].track_start);
		end
		next_typed = 1'b0;
		next_event = '0;

		// random track bodies
		new_track = 1'b1;
		while (bytes_sent - bytes_ignored < dir_rows.size() + RANDOM_BYTES) begin
			if (bytes_sent > 800 && !hold_started) begin
				hold_started = 1'b1;
				hold_req     = 1'b1;
			end
			if ($urandom_range(0, 149) == 0)
				steady = !steady;
			send_delta(new_track);
			new_track = 1'b0;
			ch = 4'($urandom);
			r  = $urandom_range(0, 99);
			if (r < 30) begin
				send_byte(($urandom_range(0, 1) ? ST_NOTE_ON : ST_NOTE_OFF) | {4'h0, ch}, 1'b0);
				send_payload(2);
			end else if (r < 50) begin
				send_byte(8'($urandom_range(0, 127)), 1'b0);
				send_payload(1);
			end else if (r < 58) begin
				k = $urandom_range(0, 2);
				send_byte(((k == 0) ? ST_POLY_AT : (k == 1) ? ST_CTRL : ST_PITCH)
					| {4'h0, ch}, 1'b0);
				send_payload(2);
			end else if (r < 63) begin
				send_byte(($urandom_range(0, 1) ? ST_PROG : ST_CHAN_AT) | {4'h0, ch}, 1'b0);
				send_payload(1);
			end else if (r < 69) begin
				send_byte($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC, 1'b0);
				len = pick_len();
				send_varlen(len, 1'b0);
				send_payload(len);
			end else if (r < 77) begin
				send_byte(ST_META, 1'b0);
				do
					t = 8'($urandom);
				while (t == META_END_TRACK || t == META_TEMPO);
				send_byte(t, 1'b0);
				len = pick_len();
				send_varlen(len, 1'b0);
				send_payload(len);
			end else if (r < 85) begin
				k = $urandom_range(0, 9);
				len = (k < 6) ? 3 : (k == 6) ? 0 : (k == 7) ? $urandom_range(1, 2)
					: $urandom_range(4, 6);
				send_byte(ST_META, 1'b0);
				send_byte(META_TEMPO, 1'b0);
				send_varlen(len, 1'b0);
				send_payload(len);
			end else if (r < 88) begin
				send_byte(ST_META, 1'b0);
				send_byte(META_END_TRACK, 1'b0);
				send_varlen(($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : 0, 1'b0);
				// trailing bytes after end of track are ignored
				k = $urandom_range(0, 4);
				send_payload(k);
				bytes_ignored += k;
				new_track = 1'b1;
			end else if (r < 92) begin
				// undefined system status bytes
				k = $urandom_range(1, 13);
				send_byte(ST_SYSTEM + 8'((k < 7) ? k : k + 1), 1'b0);
			end else if (r < 96) begin
				// message cut short by a new track
				send_byte(ST_NOTE_ON | {4'h0, ch}, 1'b0);
				if ($urandom_range(0, 1))
					send_payload(1);
				new_track = 1'b1;
			end else begin
				send_byte(8'($urandom), $urandom_range(0, 9) == 0);
				new_track = 1'b1;
			end
		end
		steady = 1'b0;

		@(negedge clk);
		byte_if.valid <= 1'b0;

		while (expected_events.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("bytes in %0d (%0d ignored); results: %0d notes, %0d tempo, %0d end of track",
			bytes_sent, bytes_ignored, n_notes, n_tempos, n_ends);
		$display("store-full events %0d, long receiver hold-off done %0d", n_full, hold_done);
		if (fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mtep_pkg.sv
rtl/core/mtep_stream_if.sv
rtl/core/mtep_parser.sv
rtl/core/mtep_out_stage.sv
rtl/core/midi_track_event_parser.sv
rtl/core/mtep_checker.sv
verif/midi_track_event_parser_tb.sv
